### rtl/segment_box_intersection_test_core_macros.svh
// Assertion macros used by the checker of the segment/box intersection core.
`ifndef SEGMENT_BOX_INTERSECTION_TEST_CORE_MACROS_SVH
`define SEGMENT_BOX_INTERSECTION_TEST_CORE_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define SBIT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SBIT_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sbit_pkg.sv
// Shared types, constants and sign helpers of the segment/box intersection core.
`timescale 1ns / 1ps
package sbit_pkg;

    localparam int SIZE_BITS    = 12;
    localparam int REG_IDX_BITS = 1;
    localparam logic [SIZE_BITS-1:0] BOX_SIZE_RESET = 12'd256;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_BOX_WIDTH  = 1'b0,
        REG_BOX_HEIGHT = 1'b1
    } t_reg_idx;

    // Three-valued sign: -1, 0 or +1.
    typedef logic signed [1:0] t_sgn;

    // Load strobes of the four pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_pipe_ctl;

    function automatic t_sgn f_mk_sgn(input logic neg, input logic nz);
        t_sgn s;
        if (neg) begin
            s = -2'sd1;
        end else if (nz) begin
            s = 2'sd1;
        end else begin
            s = 2'sd0;
        end
        return s;
    endfunction

    function automatic t_sgn f_neg(input t_sgn a);
        return t_sgn'(2'sd0 - a);
    endfunction

    // Both intersection parameters inside [0,1], judged from the signs of the
    // denominator, the numerators and the numerators minus the denominator.
    function automatic logic f_edge_hit(input t_sgn sd, input t_sgn sn1, input t_sgn sm1,
                                        input t_sgn sn2, input t_sgn sm2);
        return (sd != 2'sd0) && (sn1 != f_neg(sd)) && (sm1 != sd) &&
               (sn2 != f_neg(sd)) && (sm2 != sd);
    endfunction

endpackage

### rtl/sbit_front.sv
// Stages 1 and 2: box corners, segment direction and corner offsets.
`timescale 1ns / 1ps
module sbit_front
    import sbit_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  t_pipe_ctl                     i_ctl,
    input  logic [SIZE_BITS-1:0]          i_box_w,
    input  logic [SIZE_BITS-1:0]          i_box_h,
    input  logic signed [COORD_BITS-1:0]  i_sx,
    input  logic signed [COORD_BITS-1:0]  i_sy,
    input  logic signed [COORD_BITS-1:0]  i_ex,
    input  logic signed [COORD_BITS-1:0]  i_ey,
    input  logic signed [COORD_BITS-1:0]  i_cx,
    input  logic signed [COORD_BITS-1:0]  i_cy,
    output logic signed [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)+2:0] o_dxl,
    output logic signed [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)+2:0] o_dxr,
    output logic signed [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)+2:0] o_dyt,
    output logic signed [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)+2:0] o_dyb,
    output t_sgn                          o_sxle,
    output t_sgn                          o_sxre,
    output t_sgn                          o_syte,
    output t_sgn                          o_sybe,
    output logic signed [COORD_BITS+1:0]  o_v1x,
    output logic signed [COORD_BITS+1:0]  o_v1y,
    output logic                          o_wnz,
    output logic                          o_hnz
);

    localparam int HW  = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int PW  = HW + 2;          // doubled corner coordinate
    localparam int DW  = PW + 1;          // corner minus segment point
    localparam int VW  = COORD_BITS + 2;  // doubled segment direction

    logic signed [PW-1:0] sx_e, sy_e, ex_e, ey_e, cx_e, cy_e, w_e, h_e;

    logic signed [PW-1:0] n1_sx, n1_sy, n1_ex, n1_ey, n1_xl, n1_xr, n1_yt, n1_yb;
    logic signed [VW-1:0] n1_v1x, n1_v1y;
    logic signed [PW-1:0] r1_sx, r1_sy, r1_ex, r1_ey, r1_xl, r1_xr, r1_yt, r1_yb;
    logic signed [VW-1:0] r1_v1x, r1_v1y;
    logic                 r1_wnz, r1_hnz;

    logic signed [DW-1:0] n2_dxl, n2_dxr, n2_dyt, n2_dyb;
    logic signed [DW-1:0] exl, exr, eyt, eyb;

    // Work on doubled coordinates so the half box size stays exact.
    assign sx_e = PW'(i_sx) <<< 1;
    assign sy_e = PW'(i_sy) <<< 1;
    assign ex_e = PW'(i_ex) <<< 1;
    assign ey_e = PW'(i_ey) <<< 1;
    assign cx_e = PW'(i_cx) <<< 1;
    assign cy_e = PW'(i_cy) <<< 1;
    assign w_e  = PW'(signed'({1'b0, i_box_w}));
    assign h_e  = PW'(signed'({1'b0, i_box_h}));

    always_comb begin
        n1_sx  = sx_e;
        n1_sy  = sy_e;
        n1_ex  = ex_e;
        n1_ey  = ey_e;
        n1_xl  = cx_e - w_e;
        n1_xr  = cx_e + w_e;
        n1_yt  = cy_e - h_e;
        n1_yb  = cy_e + h_e;
        n1_v1x = VW'(ex_e - sx_e);
        n1_v1y = VW'(ey_e - sy_e);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r1_sx  <= n1_sx;
            r1_sy  <= n1_sy;
            r1_ex  <= n1_ex;
            r1_ey  <= n1_ey;
            r1_xl  <= n1_xl;
            r1_xr  <= n1_xr;
            r1_yt  <= n1_yt;
            r1_yb  <= n1_yb;
            r1_v1x <= n1_v1x;
            r1_v1y <= n1_v1y;
            r1_wnz <= |i_box_w;
            r1_hnz <= |i_box_h;
        end
    end

    always_comb begin
        n2_dxl = DW'(r1_xl) - DW'(r1_sx);
        n2_dxr = DW'(r1_xr) - DW'(r1_sx);
        n2_dyt = DW'(r1_yt) - DW'(r1_sy);
        n2_dyb = DW'(r1_yb) - DW'(r1_sy);
        exl    = DW'(r1_xl) - DW'(r1_ex);
        exr    = DW'(r1_xr) - DW'(r1_ex);
        eyt    = DW'(r1_yt) - DW'(r1_ey);
        eyb    = DW'(r1_yb) - DW'(r1_ey);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            o_dxl  <= n2_dxl;
            o_dxr  <= n2_dxr;
            o_dyt  <= n2_dyt;
            o_dyb  <= n2_dyb;
            o_sxle <= f_mk_sgn(exl[DW-1], |exl);
            o_sxre <= f_mk_sgn(exr[DW-1], |exr);
            o_syte <= f_mk_sgn(eyt[DW-1], |eyt);
            o_sybe <= f_mk_sgn(eyb[DW-1], |eyb);
            o_v1x  <= r1_v1x;
            o_v1y  <= r1_v1y;
            o_wnz  <= r1_wnz;
            o_hnz  <= r1_hnz;
        end
    end

endmodule

### rtl/sbit_cross.sv
// Stages 3 and 4: corner cross products and the per-edge parameter tests.
`timescale 1ns / 1ps
module sbit_cross
    import sbit_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  t_pipe_ctl                     i_ctl,
    input  logic signed [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)+2:0] i_dxl,
    input  logic signed [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)+2:0] i_dxr,
    input  logic signed [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)+2:0] i_dyt,
    input  logic signed [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)+2:0] i_dyb,
    input  t_sgn                          i_sxle,
    input  t_sgn                          i_sxre,
    input  t_sgn                          i_syte,
    input  t_sgn                          i_sybe,
    input  logic signed [COORD_BITS+1:0]  i_v1x,
    input  logic signed [COORD_BITS+1:0]  i_v1y,
    input  logic                          i_wnz,
    input  logic                          i_hnz,
    output logic                          o_hit
);

    localparam int HW  = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int DW  = HW + 3;
    localparam int VW  = COORD_BITS + 2;
    localparam int PRW = DW + VW;

    logic signed [PRW-1:0] n3_pl, n3_pr, n3_pt, n3_pb;
    logic signed [PRW-1:0] r3_pl, r3_pr, r3_pt, r3_pb;
    t_sgn r3_sdxl, r3_sdxr, r3_sdyt, r3_sdyb;
    t_sgn r3_sxle, r3_sxre, r3_syte, r3_sybe;
    t_sgn r3_sv1x, r3_sv1y;
    logic r3_wnz, r3_hnz;

    logic signed [PRW:0] d_tl, d_tr, d_br, d_bl;
    t_sgn c_tl, c_tr, c_br, c_bl;
    logic hit_top, hit_right, hit_bottom, hit_left;
    logic n4_hit;

    // Only four distinct products: each corner cross term is a difference of two of them.
    always_comb begin
        n3_pl = i_dxl * i_v1y;
        n3_pr = i_dxr * i_v1y;
        n3_pt = i_dyt * i_v1x;
        n3_pb = i_dyb * i_v1x;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r3_pl   <= n3_pl;
            r3_pr   <= n3_pr;
            r3_pt   <= n3_pt;
            r3_pb   <= n3_pb;
            r3_sdxl <= f_mk_sgn(i_dxl[DW-1], |i_dxl);
            r3_sdxr <= f_mk_sgn(i_dxr[DW-1], |i_dxr);
            r3_sdyt <= f_mk_sgn(i_dyt[DW-1], |i_dyt);
            r3_sdyb <= f_mk_sgn(i_dyb[DW-1], |i_dyb);
            r3_sxle <= i_sxle;
            r3_sxre <= i_sxre;
            r3_syte <= i_syte;
            r3_sybe <= i_sybe;
            r3_sv1x <= f_mk_sgn(i_v1x[VW-1], |i_v1x);
            r3_sv1y <= f_mk_sgn(i_v1y[VW-1], |i_v1y);
            r3_wnz  <= i_wnz;
            r3_hnz  <= i_hnz;
        end
    end

    // Side of the segment line on which each corner lies.
    always_comb begin
        d_tl = (PRW+1)'(r3_pl) - (PRW+1)'(r3_pt);
        d_tr = (PRW+1)'(r3_pr) - (PRW+1)'(r3_pt);
        d_br = (PRW+1)'(r3_pr) - (PRW+1)'(r3_pb);
        d_bl = (PRW+1)'(r3_pl) - (PRW+1)'(r3_pb);
        c_tl = f_mk_sgn(d_tl[PRW], |d_tl);
        c_tr = f_mk_sgn(d_tr[PRW], |d_tr);
        c_br = f_mk_sgn(d_br[PRW], |d_br);
        c_bl = f_mk_sgn(d_bl[PRW], |d_bl);
    end

    // Edges are axis aligned, so each edge-side cross product reduces to a sign.
    always_comb begin
        hit_top    = r3_wnz && f_edge_hit(f_neg(r3_sv1y), f_neg(r3_sdyt), f_neg(r3_syte),
                                          c_tl, c_tr);
        hit_right  = r3_hnz && f_edge_hit(r3_sv1x, r3_sdxr, r3_sxre, c_tr, c_br);
        hit_bottom = r3_wnz && f_edge_hit(r3_sv1y, r3_sdyb, r3_sybe, c_br, c_bl);
        hit_left   = r3_hnz && f_edge_hit(f_neg(r3_sv1x), f_neg(r3_sdxl), f_neg(r3_sxle),
                                          c_bl, c_tl);
        n4_hit     = hit_top || hit_right || hit_bottom || hit_left;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            o_hit <= n4_hit;
        end
    end

endmodule

### rtl/segment_box_intersection_test_core.sv
// Top level of the segment/box outline intersection core.
//
// Usage: an input transaction on i_in_valid/o_in_ready carries a segment
// (start and end point) and a box centre, all signed fixed point. The box
// width and height come from two registers written through i_cfg_we,
// i_cfg_idx and i_cfg_data (index 0 width, index 1 height); write them only
// while no transaction is in flight. Each input yields one result
// transaction on o_out_valid/i_out_ready: o_hit is set when the segment
// crosses or touches any of the four box edges.
// From input acceptance, a transaction passes four register stages (corners,
// offsets, four signed multipliers, cross-sign compare) to o_out_valid;
// throughput is one transaction per cycle while the receiver does not stall.
// Reset empties the pipeline and loads both box sizes with BOX_SIZE_RESET (256).
// When the receiver stalls, the result is held and upstream stages keep
// filling bubbles; o_in_ready drops only when all four stages hold data.
`timescale 1ns / 1ps
module segment_box_intersection_test_core
    import sbit_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [REG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [SIZE_BITS-1:0]          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_BITS-1:0]  i_seg_start_x,
    input  logic signed [COORD_BITS-1:0]  i_seg_start_y,
    input  logic signed [COORD_BITS-1:0]  i_seg_end_x,
    input  logic signed [COORD_BITS-1:0]  i_seg_end_y,
    input  logic signed [COORD_BITS-1:0]  i_box_center_x,
    input  logic signed [COORD_BITS-1:0]  i_box_center_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit
);

    localparam int HW = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int DW = HW + 3;
    localparam int VW = COORD_BITS + 2;

    logic [SIZE_BITS-1:0] r_box_w, r_box_h;
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic                 en1, en2, en3, en4;
    t_pipe_ctl            ctl;

    logic signed [DW-1:0] dxl, dxr, dyt, dyb;
    t_sgn                 sxle, sxre, syte, sybe;
    logic signed [VW-1:0] v1x, v1y;
    logic                 wnz, hnz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w <= BOX_SIZE_RESET;
            r_box_h <= BOX_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_BOX_WIDTH:  r_box_w <= i_cfg_data;
                REG_BOX_HEIGHT: r_box_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en4        = !r_v4 || i_out_ready;
        en3        = !r_v3 || en4;
        en2        = !r_v2 || en3;
        en1        = !r_v1 || en2;
        o_in_ready = en1;
        ctl.ld1    = en1 && i_in_valid;
        ctl.ld2    = en2 && r_v1;
        ctl.ld3    = en3 && r_v2;
        ctl.ld4    = en4 && r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    assign o_out_valid = r_v4;

    sbit_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_box_w (r_box_w),
        .i_box_h (r_box_h),
        .i_sx    (i_seg_start_x),
        .i_sy    (i_seg_start_y),
        .i_ex    (i_seg_end_x),
        .i_ey    (i_seg_end_y),
        .i_cx    (i_box_center_x),
        .i_cy    (i_box_center_y),
        .o_dxl   (dxl),
        .o_dxr   (dxr),
        .o_dyt   (dyt),
        .o_dyb   (dyb),
        .o_sxle  (sxle),
        .o_sxre  (sxre),
        .o_syte  (syte),
        .o_sybe  (sybe),
        .o_v1x   (v1x),
        .o_v1y   (v1y),
        .o_wnz   (wnz),
        .o_hnz   (hnz)
    );

    sbit_cross #(
        .COORD_BITS(COORD_BITS)
    ) u_cross (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_dxl   (dxl),
        .i_dxr   (dxr),
        .i_dyt   (dyt),
        .i_dyb   (dyb),
        .i_sxle  (sxle),
        .i_sxre  (sxre),
        .i_syte  (syte),
        .i_sybe  (sybe),
        .i_v1x   (v1x),
        .i_v1y   (v1y),
        .i_wnz   (wnz),
        .i_hnz   (hnz),
        .o_hit   (o_hit)
    );

endmodule

### rtl/sbit_checker.sv
// Port-level checker of the segment/box intersection core, bound to the top level.
`timescale 1ns / 1ps
`include "segment_box_intersection_test_core_macros.svh"
module sbit_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_hit
);

    // Hold a stalled result transaction.
    `SBIT_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit), "stalled result dropped or changed")

    // Never block input while the output stage is empty.
    `SBIT_ASSERT_RST(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input blocked with empty output stage")

    // With the receiver kept ready meanwhile, an accepted input reaches the output stage.
    `SBIT_ASSERT_RST(a_latency, i_clk, i_rst_n, (i_in_valid && o_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> o_out_valid, "result missing after pipeline latency")

    // Drain everything on reset.
    `SBIT_ASSERT(a_reset_empty, i_clk, !$past(i_rst_n) && i_rst_n |-> !o_out_valid && o_in_ready, "pipeline not empty after reset")

endmodule

bind segment_box_intersection_test_core sbit_checker u_sbit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_hit       (o_hit)
);
